// ----- sv/xfc_pkg.sv -----
package xfc_pkg;

  localparam int FRAME_BYTES   = 8;
  localparam int PAYLOAD_BYTES = 4;
  localparam int BEAT_W        = $clog2(FRAME_BYTES);
  localparam int CFG_IDX_W     = 8;

  localparam logic [7:0] HEAD_RESET = 8'hF5;
  localparam logic [7:0] TAIL_RESET = 8'hF5;

  // Request selector codes
  typedef enum logic [1:0] {
    FUNC_SEND  = 2'd0,
    FUNC_RX    = 2'd1,
    FUNC_FLUSH = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  typedef enum logic {
    KIND_TX = 1'b0,
    KIND_RX = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD_HT  = 2'd1,
    ST_BAD_SUM = 2'd2,
    ST_RSVD    = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HEAD = 8'd0,
    CFG_TAIL = 8'd1
  } cfg_idx_t;

  // One result as it travels to the output register
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  tx_byte;
    logic        last;
    logic [7:0]  resp0;
    logic [7:0]  resp1;
    logic [7:0]  resp2;
    logic [7:0]  resp3;
    status_t     status;
  } res_t;

endpackage

// ----- sv/xfc_tx_framer.sv -----
module xfc_tx_framer (
  input  logic [xfc_pkg::BEAT_W-1:0] beat,
  input  logic [7:0]                 cmd0,
  input  logic [7:0]                 cmd1,
  input  logic [7:0]                 cmd2,
  input  logic [7:0]                 cmd3,
  input  logic [7:0]                 head,
  input  logic [7:0]                 tail,
  output logic [7:0]                 tx_byte
);
  import xfc_pkg::*;

  logic [7:0] csum;

  // Checksum over frame bytes 1..5; byte 5 is zero
  assign csum = cmd0 ^ cmd1 ^ cmd2 ^ cmd3;

  // Pick the frame byte for this beat
  always_comb begin
    unique case (beat)
      3'd0:    tx_byte = head;
      3'd1:    tx_byte = cmd0;
      3'd2:    tx_byte = cmd1;
      3'd3:    tx_byte = cmd2;
      3'd4:    tx_byte = cmd3;
      3'd5:    tx_byte = 8'h00;
      3'd6:    tx_byte = csum;
      default: tx_byte = tail;
    endcase
  end

endmodule

// ----- sv/xfc_rx_deframer.sv -----
module xfc_rx_deframer (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          step_en,
  input  logic          flush_en,
  input  logic [7:0]    rx_byte,
  input  logic [7:0]    head,
  input  logic [7:0]    tail,
  output logic          at_last,
  output xfc_pkg::res_t res
);
  import xfc_pkg::*;

  logic [BEAT_W-1:0] pos_r, pos_nxt;
  logic [7:0]        xor_r, xor_nxt;
  logic              head_ok_r, head_ok_nxt;
  logic              sum_ok_r, sum_ok_nxt;
  logic [7:0]        pay_r [PAYLOAD_BYTES];
  logic [1:0]        pay_idx;
  logic              pay_we;
  logic [BEAT_W-1:0] pos_m1;
  status_t           status;

  assign at_last = (pos_r == BEAT_W'(FRAME_BYTES - 1));
  assign pos_m1  = pos_r - BEAT_W'(1);
  assign pay_idx = pos_m1[1:0];
  assign pay_we  = step_en && (pos_r >= BEAT_W'(1)) && (pos_r <= BEAT_W'(PAYLOAD_BYTES));

  // Advance the frame tracking state
  always_comb begin
    pos_nxt     = pos_r;
    xor_nxt     = xor_r;
    head_ok_nxt = head_ok_r;
    sum_ok_nxt  = sum_ok_r;
    if (flush_en) begin
      pos_nxt     = '0;
      xor_nxt     = '0;
      head_ok_nxt = 1'b0;
      sum_ok_nxt  = 1'b0;
    end else if (step_en) begin
      pos_nxt = pos_r + BEAT_W'(1);
      priority if (pos_r == BEAT_W'(0)) begin
        head_ok_nxt = (rx_byte == head);
        xor_nxt     = '0;
        sum_ok_nxt  = 1'b0;
      end else if (pos_r <= BEAT_W'(5)) begin
        xor_nxt = xor_r ^ rx_byte;
      end else if (pos_r == BEAT_W'(6)) begin
        sum_ok_nxt = (xor_r == rx_byte);
      end else begin
        xor_nxt     = '0;
        head_ok_nxt = 1'b0;
        sum_ok_nxt  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      xor_r     <= '0;
      head_ok_r <= 1'b0;
      sum_ok_r  <= 1'b0;
    end else begin
      pos_r     <= pos_nxt;
      xor_r     <= xor_nxt;
      head_ok_r <= head_ok_nxt;
      sum_ok_r  <= sum_ok_nxt;
    end
  end

  // Store payload bytes 1..4 of the frame
  always_ff @(posedge clk) begin
    if (pay_we) begin
      pay_r[pay_idx] <= rx_byte;
    end
  end

  // Status: head/tail error wins over checksum error
  always_comb begin
    priority if (!head_ok_r || (rx_byte != tail)) begin
      status = ST_BAD_HT;
    end else if (!sum_ok_r) begin
      status = ST_BAD_SUM;
    end else begin
      status = ST_OK;
    end
  end

  always_comb begin
    res.kind    = KIND_RX;
    res.tx_byte = 8'h00;
    res.last    = 1'b1;
    res.resp0   = pay_r[0];
    res.resp1   = pay_r[1];
    res.resp2   = pay_r[2];
    res.resp3   = pay_r[3];
    res.status  = status;
  end

endmodule

// ----- sv/xor_checked_frame_codec_top.sv -----
// Channel | Direction | Handshake          | Payload
// in_     | input     | in_valid/in_ready  | func, cmd_byte0..3, rx_byte
// out_    | output    | out_valid/out_ready| kind, tx_byte, last, resp_byte0..3, rx_status
// cfg_    | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// For a send request, the input register steps the frame sequencer one byte per cycle
// into the output register while the output is not stalled. Received bytes, flushes and
// unused selectors retire without stepping the sequencer. Reset (rst_n low, synchronous)
// clears the receive tracking and restores both marker bytes to 0xF5. A stalled output
// holds the sequencer; the input register still takes a new request while it is empty.
module xor_checked_frame_codec_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_func,
  input  logic [7:0]                    in_cmd_byte0,
  input  logic [7:0]                    in_cmd_byte1,
  input  logic [7:0]                    in_cmd_byte2,
  input  logic [7:0]                    in_cmd_byte3,
  input  logic [7:0]                    in_rx_byte,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_kind,
  output logic [7:0]                    out_tx_byte,
  output logic                          out_last,
  output logic [7:0]                    out_resp_byte0,
  output logic [7:0]                    out_resp_byte1,
  output logic [7:0]                    out_resp_byte2,
  output logic [7:0]                    out_resp_byte3,
  output logic [1:0]                    out_rx_status,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [xfc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                    cfg_data
);
  import xfc_pkg::*;

  logic [7:0]        head_r, tail_r;
  logic              s1_valid_r, s1_valid_nxt;
  func_t             s1_func_r;
  logic [7:0]        s1_cmd0_r, s1_cmd1_r, s1_cmd2_r, s1_cmd3_r, s1_rxb_r;
  logic [BEAT_W-1:0] beat_r, beat_nxt;
  logic              out_valid_r, out_valid_nxt;
  res_t              out_r;
  res_t              tx_res, rx_res, new_res;
  logic [7:0]        tx_byte;
  logic              rx_at_last;
  logic              is_send, is_rx, emits, out_free, fire, done, beat_last, in_acc;

  assign cfg_ready = 1'b1;

  // Marker registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= HEAD_RESET;
      tail_r <= TAIL_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_HEAD) head_r <= cfg_data;
      if (cfg_index == CFG_TAIL) tail_r <= cfg_data;
    end
  end

  // Issue control
  assign is_send   = s1_valid_r && (s1_func_r == FUNC_SEND);
  assign is_rx     = s1_valid_r && (s1_func_r == FUNC_RX);
  assign beat_last = (beat_r == BEAT_W'(FRAME_BYTES - 1));
  assign emits     = is_send || (is_rx && rx_at_last);
  assign out_free  = !out_valid_r || out_ready;
  assign fire      = s1_valid_r && (out_free || !emits);
  assign done      = fire && (!is_send || beat_last);
  assign in_ready  = !s1_valid_r || done;
  assign in_acc    = in_valid && in_ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    beat_nxt     = beat_r;
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (done) begin
      s1_valid_nxt = 1'b0;
    end
    if (done) begin
      beat_nxt = '0;
    end else if (fire) begin
      beat_nxt = beat_r + BEAT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      beat_r     <= '0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      beat_r     <= beat_nxt;
    end
  end

  // Capture the request payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_func_r <= func_t'(in_func);
      s1_cmd0_r <= in_cmd_byte0;
      s1_cmd1_r <= in_cmd_byte1;
      s1_cmd2_r <= in_cmd_byte2;
      s1_cmd3_r <= in_cmd_byte3;
      s1_rxb_r  <= in_rx_byte;
    end
  end

  xfc_tx_framer u_tx (
    .beat    (beat_r),
    .cmd0    (s1_cmd0_r),
    .cmd1    (s1_cmd1_r),
    .cmd2    (s1_cmd2_r),
    .cmd3    (s1_cmd3_r),
    .head    (head_r),
    .tail    (tail_r),
    .tx_byte (tx_byte)
  );

  xfc_rx_deframer u_rx (
    .clk      (clk),
    .rst_n    (rst_n),
    .step_en  (fire && is_rx),
    .flush_en (fire && s1_valid_r && (s1_func_r == FUNC_FLUSH)),
    .rx_byte  (s1_rxb_r),
    .head     (head_r),
    .tail     (tail_r),
    .at_last  (rx_at_last),
    .res      (rx_res)
  );

  // Select the result to load
  always_comb begin
    tx_res.kind    = KIND_TX;
    tx_res.tx_byte = tx_byte;
    tx_res.last    = beat_last;
    tx_res.resp0   = 8'h00;
    tx_res.resp1   = 8'h00;
    tx_res.resp2   = 8'h00;
    tx_res.resp3   = 8'h00;
    tx_res.status  = ST_OK;
    new_res        = is_send ? tx_res : rx_res;
  end

  // Output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (fire && emits) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emits) begin
      out_r <= new_res;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_kind       = out_r.kind;
  assign out_tx_byte    = out_r.tx_byte;
  assign out_last       = out_r.last;
  assign out_resp_byte0 = out_r.resp0;
  assign out_resp_byte1 = out_r.resp1;
  assign out_resp_byte2 = out_r.resp2;
  assign out_resp_byte3 = out_r.resp3;
  assign out_rx_status  = out_r.status;

  // A decoded frame is always a single, final result with no transmit byte
  a_rx_res_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_r.kind == KIND_RX)) |-> (out_r.last && (out_r.tx_byte == 8'h00)))
    else $error("decoded frame result malformed");

  // Transmit results carry no receive status
  a_tx_no_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_r.kind == KIND_TX)) |-> (out_r.status == ST_OK))
    else $error("transmit result with receive status");

  // A send request leaves the input register only on its final byte
  a_send_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    (is_send && done) |=> (out_valid_r && out_r.last && (out_r.kind == KIND_TX)))
    else $error("send request retired before its final byte");

  // The sequencer never holds a non-send request past its first beat
  a_beat_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !is_send) |-> (beat_r == '0))
    else $error("beat counter advanced on a non-send request");

endmodule
